// ===== design/itfr_pkg.sv =====
// ----------------------------------------------------------------------------
// itfr_pkg
// Shared types and constants for the ISO-TP frame reassembler: frame type
// codes, result status codes, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package itfr_pkg;

  localparam int IdW    = 12;
  localparam int ByteW  = 8;
  localparam int LenW   = 12;
  localparam int NumDat = 7;
  localparam int PtrW   = 3;

  localparam logic [3:0] FT_SINGLE = 4'd0;
  localparam logic [3:0] FT_FIRST  = 4'd1;
  localparam logic [3:0] FT_CONSEC = 4'd2;
  localparam logic [3:0] FT_FLOW   = 4'd3;

  localparam logic [3:0]      SF_MAX_LEN    = 4'd7;
  localparam logic [LenW-1:0] FF_MIN_LEN    = 12'd7;
  localparam logic [LenW-1:0] FF_DATA_BYTES = 12'd6;
  localparam logic [LenW-1:0] CF_DATA_BYTES = 12'd7;
  localparam logic [PtrW-1:0] FF_FIRST_IDX  = 3'd1;
  localparam logic [PtrW-1:0] FF_COUNT      = 3'd6;
  localparam logic [PtrW-1:0] CF_COUNT      = 3'd7;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TYPE = 2'd1,
    ST_BAD_LEN  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EMIT = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic has_results;
    logic last_beat;
  } stat_t;

endpackage

// ===== design/itfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// itfr_ctrl
// Controller: takes one frame while idle, then hands out its results, if any,
// one transaction per cycle while out_tready is high, until the last is taken.
// ----------------------------------------------------------------------------
module itfr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  itfr_pkg::stat_t stat,
  output itfr_pkg::cmd_t  cmd
);

  itfr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itfr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    case (state_r)
      itfr_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (stat.has_results) begin
            state_nxt = itfr_pkg::S_EMIT;
          end
        end
      end
      itfr_pkg::S_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.advance = 1'b1;
          if (stat.last_beat) begin
            state_nxt = itfr_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = itfr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/itfr_datapath.sv =====
// ----------------------------------------------------------------------------
// itfr_datapath
// Datapath: decodes the frame type, keeps the open-message length and halt
// flag, holds the frame bytes and steps a byte pointer over the results.
// ----------------------------------------------------------------------------
module itfr_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [itfr_pkg::IdW-1:0]       can_id,
  input  logic [itfr_pkg::ByteW-1:0]     pci_byte,
  input  logic [itfr_pkg::ByteW-1:0]     data_in [itfr_pkg::NumDat],
  input  itfr_pkg::cmd_t                 cmd,
  output itfr_pkg::stat_t                stat,
  output logic [itfr_pkg::IdW-1:0]       header_out,
  output logic [itfr_pkg::ByteW-1:0]     payload_byte,
  output logic                           byte_valid,
  output logic                           message_first,
  output logic                           message_last,
  output logic                           run_last,
  output itfr_pkg::status_t              status
);

  // model state
  logic [itfr_pkg::LenW-1:0] rem_r, rem_nxt;
  logic                      open_r, open_nxt;
  logic                      halt_r, halt_nxt;

  // current frame
  logic [itfr_pkg::IdW-1:0]   hdr_r;
  logic [itfr_pkg::ByteW-1:0] bytes_r [itfr_pkg::NumDat];
  logic [itfr_pkg::PtrW-1:0]  ptr_r, ptr_nxt;
  logic [itfr_pkg::PtrW-1:0]  left_r, left_nxt;
  logic                       valid_r, valid_nxt;
  logic                       first_r, first_nxt;
  logic                       close_r, close_nxt;
  logic                       beat0_r;
  itfr_pkg::status_t          status_r, status_nxt;

  logic [3:0]                ftype;
  logic [3:0]                flow;
  logic [itfr_pkg::LenW-1:0] ff_len;
  logic [itfr_pkg::LenW-1:0] cf_take;
  logic                      has_res;

  assign ftype   = pci_byte[7:4];
  assign flow    = pci_byte[3:0];
  assign ff_len  = {flow, data_in[0]};
  assign cf_take = (rem_r > itfr_pkg::CF_DATA_BYTES) ? itfr_pkg::CF_DATA_BYTES : rem_r;

  always_comb begin
    rem_nxt    = rem_r;
    open_nxt   = open_r;
    halt_nxt   = halt_r;
    has_res    = 1'b0;
    ptr_nxt    = '0;
    left_nxt   = 3'd1;
    valid_nxt  = 1'b0;
    first_nxt  = 1'b0;
    close_nxt  = 1'b0;
    status_nxt = itfr_pkg::ST_OK;
    if (!halt_r) begin
      case (ftype)
        itfr_pkg::FT_SINGLE: begin
          has_res = 1'b1;
          if (flow > itfr_pkg::SF_MAX_LEN) begin
            status_nxt = itfr_pkg::ST_BAD_LEN;
          end else if (flow == 4'd0) begin
            first_nxt = 1'b1;
            close_nxt = 1'b1;
          end else begin
            valid_nxt = 1'b1;
            first_nxt = 1'b1;
            close_nxt = 1'b1;
            left_nxt  = flow[itfr_pkg::PtrW-1:0];
          end
        end
        itfr_pkg::FT_FIRST: begin
          has_res = 1'b1;
          if (ff_len < itfr_pkg::FF_MIN_LEN) begin
            open_nxt   = 1'b0;
            rem_nxt    = '0;
            status_nxt = itfr_pkg::ST_BAD_LEN;
          end else begin
            open_nxt  = 1'b1;
            rem_nxt   = ff_len - itfr_pkg::FF_DATA_BYTES;
            valid_nxt = 1'b1;
            first_nxt = 1'b1;
            ptr_nxt   = itfr_pkg::FF_FIRST_IDX;
            left_nxt  = itfr_pkg::FF_COUNT;
          end
        end
        itfr_pkg::FT_CONSEC: begin
          if (open_r && (rem_r != '0)) begin
            has_res   = 1'b1;
            rem_nxt   = rem_r - cf_take;
            valid_nxt = 1'b1;
            left_nxt  = cf_take[itfr_pkg::PtrW-1:0];
            if (rem_r == cf_take) begin
              close_nxt = 1'b1;
              open_nxt  = 1'b0;
            end
          end
        end
        itfr_pkg::FT_FLOW: begin
          has_res = 1'b0;
        end
        default: begin
          has_res    = 1'b1;
          halt_nxt   = 1'b1;
          open_nxt   = 1'b0;
          rem_nxt    = '0;
          status_nxt = itfr_pkg::ST_BAD_TYPE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      open_r <= 1'b0;
      halt_r <= 1'b0;
    end else if (cmd.load) begin
      rem_r  <= rem_nxt;
      open_r <= open_nxt;
      halt_r <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hdr_r    <= can_id;
      bytes_r  <= data_in;
      ptr_r    <= ptr_nxt;
      left_r   <= left_nxt;
      valid_r  <= valid_nxt;
      first_r  <= first_nxt;
      close_r  <= close_nxt;
      status_r <= status_nxt;
      beat0_r  <= 1'b1;
    end else if (cmd.advance) begin
      ptr_r   <= ptr_r + 3'd1;
      left_r  <= left_r - 3'd1;
      beat0_r <= 1'b0;
    end
  end

  assign stat.has_results = has_res;
  assign stat.last_beat   = (left_r == 3'd1);

  assign header_out    = hdr_r;
  assign payload_byte  = valid_r ? bytes_r[ptr_r] : '0;
  assign byte_valid    = valid_r;
  assign message_first = first_r & beat0_r;
  assign message_last  = close_r & (left_r == 3'd1);
  assign run_last      = (left_r == 3'd1);
  assign status        = status_r;

endmodule

// ===== design/iso_tp_frame_reassembler.sv =====
// ----------------------------------------------------------------------------
// iso_tp_frame_reassembler
// Reassembles ISO-TP messages from CAN frames, at most one message byte per result.
// ----------------------------------------------------------------------------
// The first result is valid in the cycle after the frame transaction.
// Throughput: one result per cycle while out_tready is high; a frame holds the
// input until its N results are taken, N = 0 to 7, set by the single output byte pointer stepping the frame.
// Reset: synchronous rst_n clears the controller, open message, remaining
// count and halt flag; no clearing pass.
module iso_tp_frame_reassembler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // can_id, pci_byte, data_1 .. data_7, pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // header_out, payload_byte, pad
  output logic [4:0]  out_tuser,  // byte_valid, message_first, message_last, status
  output logic        out_tlast
);

  itfr_pkg::cmd_t    cmd;
  itfr_pkg::stat_t   stat;
  itfr_pkg::status_t status;

  logic [itfr_pkg::ByteW-1:0] data_in [itfr_pkg::NumDat];
  logic [itfr_pkg::IdW-1:0]   header_out;
  logic [itfr_pkg::ByteW-1:0] payload_byte;
  logic                       byte_valid;
  logic                       message_first;
  logic                       message_last;
  logic                       run_last;

  always_comb begin
    for (int k = 0; k < itfr_pkg::NumDat; k++) begin
      data_in[k] = in_tdata[20 + 8*k +: 8];
    end
  end

  itfr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  itfr_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .can_id        (in_tdata[11:0]),
    .pci_byte      (in_tdata[19:12]),
    .data_in       (data_in),
    .cmd           (cmd),
    .stat          (stat),
    .header_out    (header_out),
    .payload_byte  (payload_byte),
    .byte_valid    (byte_valid),
    .message_first (message_first),
    .message_last  (message_last),
    .run_last      (run_last),
    .status        (status)
  );

  assign out_tdata = {4'd0, payload_byte, header_out};
  assign out_tuser = {status, message_last, message_first, byte_valid};
  assign out_tlast = run_last;

endmodule
